// ----- rtl/core/css_pkg.sv -----
package css_pkg;

  // fixed field and register widths
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int SHIFT_W     = 4;
  localparam int CHAN_W      = 2;
  localparam int CUR_W       = 18;
  localparam int SUM_W       = 26;
  localparam int OUT_TDATA_W = 24;
  localparam int DIV_COUNT   = 3;

  localparam logic [CUR_W-1:0]   CUR_MAX   = {CUR_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_NUM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_BUS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_5V    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_12V   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DSTART,
    ST_DWAIT,
    ST_UPD,
    ST_RES
  } css_state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } css_div_stat_t;

endpackage

// ----- rtl/core/css_div.sv -----
module css_div #(
  parameter int DVD_W = 28
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DVD_W-1:0]        dividend,
  input  logic [css_pkg::CFG_W-1:0] divisor,
  output css_pkg::css_div_stat_t  stat,
  output logic [DVD_W-1:0]        quotient
);
  import css_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [CFG_W-1:0] div_r;
  logic [DVD_W-1:0] dq_r, dq_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [CFG_W:0]   trial, diff;
  logic             ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial   = {rem_r, dq_r[DVD_W-1]};
    diff    = trial - {1'b0, div_r};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
    dq_nxt  = {dq_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      dq_r  <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

endmodule

// ----- rtl/core/current_sense_scale_and_smooth_core.sv -----
// channel  direction  ports                       contents
// in       slave      in_tvalid/tready/tdata/tuser tdata: raw_sample; tuser: channel_sel
// out      master     out_tvalid/tready/tdata/tuser tdata: filtered_current_ma; tuser: channel_out
// cfg      write      cfg_we/cfg_index/cfg_wdata   one register per write, no read-back
//
// an accepted item passes through the multiply, divider start, divider wait, filter update and
// result states; the bit-serial divider produces one quotient bit per cycle
// an item for a channel without a divisor skips the arithmetic and goes straight to the result state
// rst_n is synchronous: config returns to its defaults and all filter sums clear
// in_tready is high only while idle; a finished result waits in the output register, so the
// next item is taken while out_tready is low and the sequencer holds until it is free
module current_sense_scale_and_smooth_core #(
  parameter int NUM_CHANNELS = 3,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // raw_sample
  input  logic [css_pkg::CHAN_W-1:0]          in_tuser,   // channel_sel

  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [css_pkg::OUT_TDATA_W-1:0]     out_tdata,  // filtered_current_ma
  output logic [css_pkg::CHAN_W-1:0]          out_tuser,  // channel_out

  input  logic                                cfg_we,
  input  logic [css_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [css_pkg::CFG_W-1:0]           cfg_wdata
);
  import css_pkg::*;

  localparam int PROD_W    = SAMPLE_BITS + CFG_W;
  // only channels that have both a divisor and a sum slot keep state
  localparam int NUM_STORE = (NUM_CHANNELS < DIV_COUNT) ? NUM_CHANNELS : DIV_COUNT;
  localparam int IDX_W     = (NUM_STORE > 1) ? $clog2(NUM_STORE) : 1;

  // configuration registers
  logic [CFG_W-1:0]   numer_r;
  logic [CFG_W-1:0]   div_r [DIV_COUNT];
  logic [SHIFT_W-1:0] shift_r;

  // sequencer and datapath registers
  css_state_t         state_r, state_nxt;
  logic [CHAN_W-1:0]  chan_r;
  logic [SAMPLE_BITS-1:0] raw_r;
  logic               bad_r;
  logic               seed_r;
  logic [PROD_W-1:0]  prod_r;
  logic [CUR_W-1:0]   cur_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sums_r [NUM_STORE];

  logic               out_valid_r;
  logic [CHAN_W-1:0]  out_chan_r;
  logic [CUR_W-1:0]   out_data_r;

  // divider hookup
  css_div_stat_t      div_stat;
  logic [PROD_W-1:0]  quo;
  logic               div_start;

  // combinational helpers
  logic               in_acc;
  logic               in_bad;
  logic               out_load;
  logic [SHIFT_W-1:0] shamt;
  logic [IDX_W-1:0]   idx;
  logic [SUM_W-1:0]   old_sum, old_shr;
  logic [SUM_W:0]     upd_wide;
  logic [SUM_W-1:0]   upd_sum;
  logic [SUM_W-1:0]   res_shr;
  logic [CUR_W-1:0]   res_val;
  logic [CUR_W-1:0]   quo_sat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  // channel code without a divisor or a sum slot gives zero and touches nothing
  assign in_bad    = (int'(in_tuser) >= DIV_COUNT) || (int'(in_tuser) >= NUM_CHANNELS);

  // shifts past eight behave as eight
  assign shamt = (shift_r > SHIFT_MAX) ? SHIFT_MAX : shift_r;
  assign idx   = chan_r[IDX_W-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      numer_r  <= 16'd3300;
      div_r[0] <= 16'd205;
      div_r[1] <= 16'd1229;
      div_r[2] <= 16'd2458;
      shift_r  <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_NUM: numer_r  <= cfg_wdata;
        REG_DIV_BUS:   div_r[0] <= cfg_wdata;
        REG_DIV_5V:    div_r[1] <= cfg_wdata;
        REG_DIV_12V:   div_r[2] <= cfg_wdata;
        REG_SHIFT:     shift_r  <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // shared bit-serial divider: scaled sample over the channel divisor
  assign div_start = (state_r == ST_DSTART);

  css_div #(
    .DVD_W (PROD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (div_r[chan_r]),
    .stat     (div_stat),
    .quotient (quo)
  );

  // quotient saturates to the 18-bit milliamp range (divisor zero lands here too)
  assign quo_sat = (|quo[PROD_W-1:CUR_W]) ? CUR_MAX : quo[CUR_W-1:0];

  // filter update: sum - (sum >> s) + current, saturated to 26 bits
  always_comb begin
    old_sum  = sums_r[idx];
    old_shr  = old_sum >> shamt;
    upd_wide = {1'b0, old_sum} - {1'b0, old_shr} + (SUM_W+1)'(cur_r);
    upd_sum  = upd_wide[SUM_W] ? SUM_MAX : upd_wide[SUM_W-1:0];
  end

  // result: zero for a bad channel, raw current on seeding, else the smoothed sum scaled back down
  always_comb begin
    res_shr = sum_r >> shamt;
    priority if (bad_r) begin
      res_val = '0;
    end else if (seed_r) begin
      res_val = cur_r;
    end else if (|res_shr[SUM_W-1:CUR_W]) begin
      res_val = CUR_MAX;
    end else begin
      res_val = res_shr[CUR_W-1:0];
    end
  end

  // output register frees as the downstream side takes the item
  assign out_load = (state_r == ST_RES) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = in_bad ? ST_RES : ST_MUL;
      ST_MUL:    state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT:  if (div_stat.done) state_nxt = ST_UPD;
      ST_UPD:    state_nxt = ST_RES;
      ST_RES:    if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      chan_r <= in_tuser;
      raw_r  <= in_tdata[SAMPLE_BITS-1:0];
      bad_r  <= in_bad;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(raw_r) * PROD_W'(numer_r);
    end
    if ((state_r == ST_DWAIT) && div_stat.done) begin
      cur_r <= quo_sat;
    end
    if (state_r == ST_UPD) begin
      seed_r <= (old_sum == '0);
      sum_r  <= (old_sum == '0) ? (SUM_W'(cur_r) << shamt) : upd_sum;
    end
  end

  // per-channel filter sums, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STORE; i++) begin
        sums_r[i] <= '0;
      end
    end else if (state_r == ST_UPD) begin
      // seeding: current << s never exceeds 26 bits for shifts up to eight
      sums_r[idx] <= (old_sum == '0) ? (SUM_W'(cur_r) << shamt) : upd_sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan_r <= chan_r;
      out_data_r <= res_val;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_chan_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule
